@@ rtl/relative_peak_threshold_cut_top_defines.svh @@
// Assertion macros for the relative peak threshold cut block.
// Used by relative_peak_threshold_cut_top; expects clk_i and rst_ni in scope.
`ifndef RELATIVE_PEAK_THRESHOLD_CUT_TOP_DEFINES_SVH
`define RELATIVE_PEAK_THRESHOLD_CUT_TOP_DEFINES_SVH

// Plain property checked on every rising clock edge outside reset.
`define RPTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: the consequent sequence must follow the antecedent.
`define RPTC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

@@ rtl/rptc_pkg.sv @@
// Shared types and constants for the relative peak threshold cut block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package rptc_pkg;

  // Buffer depth and derived widths.
  localparam int MaxLength = 64;
  localparam int IdxW      = (MaxLength > 1) ? $clog2(MaxLength) : 1;
  localparam int CntW      = $clog2(MaxLength + 1);

  // Fixed field widths.
  localparam int SampleW = 16;
  localparam int MagW    = 16;
  localparam int CutW    = 17;
  localparam int FracW   = 16;
  localparam int BoundW  = CutW + MagW;

  // One input request.
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      is_last;
  } rptc_in_t;

  // One result request.
  typedef struct packed {
    logic signed [SampleW-1:0] result_sample;
    logic                      result_last;
  } rptc_out_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MUL,
    ST_READ,
    ST_EMIT
  } rptc_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic mul_en;
    logic rd_en;
    logic emit_en;
    logic clear;
  } rptc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic last_idx;
  } rptc_sts_t;

  // Magnitude of a two's complement sample; -32768 maps to 32768.
  function automatic logic [MagW-1:0] mag_of(input logic signed [SampleW-1:0] s);
    logic [MagW-1:0] neg;
    neg = MagW'(-s);
    return s[SampleW-1] ? neg : MagW'(s);
  endfunction

endpackage

@@ rtl/rptc_ctrl.sv @@
// Controller state machine for the relative peak threshold cut block.
// Depends on rptc_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps

module rptc_ctrl import rptc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_is_last_i,
  input  rptc_sts_t sts_i,
  output logic      in_stall_o,
  output rptc_cmd_t cmd_o
);

  rptc_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_is_last_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_READ;
      ST_READ: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.last_idx ? ST_LOAD : ST_READ;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o    = 1'b0;
        cmd_o.load_en = in_valid_i;
      end
      ST_MUL:  cmd_o.mul_en = 1'b1;
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_EMIT: begin
        cmd_o.emit_en = sts_i.out_free;
        cmd_o.clear   = sts_i.out_free && sts_i.last_idx;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/rptc_dp.sv @@
// Datapath for the relative peak threshold cut block: sample buffer,
// peak tracker, threshold multiply, compare and output register. Uses rptc_pkg.
`timescale 1ns / 1ps

module rptc_dp import rptc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rptc_cmd_t       cmd_i,
  input  rptc_in_t        in_data_i,
  input  logic            cfg_valid_i,
  input  logic [CutW-1:0] cfg_data_i,
  input  logic            out_stall_i,
  output rptc_sts_t       sts_o,
  output logic            out_valid_o,
  output rptc_out_t       out_data_o
);

  logic [SampleW-1:0] mem_q [MaxLength];
  logic [CntW-1:0]    count_q, count_d;
  logic [MagW-1:0]    peak_q, peak_d;
  logic [CutW-1:0]    cut_q;
  logic [BoundW-1:0]  bound_q;
  logic [IdxW-1:0]    rd_idx_q, rd_idx_d;
  logic [SampleW-1:0] rd_data_q;
  logic               out_valid_q, out_valid_d;
  rptc_out_t          out_data_q;
  logic               full;
  logic [MagW-1:0]    in_mag;
  logic [MagW-1:0]    rd_mag;
  logic [BoundW-1:0]  lhs;
  logic               below;

  assign full   = (count_q == CntW'(MaxLength));
  assign in_mag = mag_of(in_data_i.sample);

  // Fill count and running peak; a request beyond the depth is dropped.
  always_comb begin
    count_d = count_q;
    peak_d  = peak_q;
    if (cmd_i.clear) begin
      count_d = '0;
      peak_d  = '0;
    end else if (cmd_i.load_en && !full) begin
      count_d = count_q + CntW'(1);
      if (in_mag > peak_q) begin
        peak_d = in_mag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      peak_q  <= '0;
      cut_q   <= '0;
    end else begin
      count_q <= count_d;
      peak_q  <= peak_d;
      if (cfg_valid_i) begin
        cut_q <= cfg_data_i;
      end
    end
  end

  // Sample buffer: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && !full) begin
      mem_q[count_q[IdxW-1:0]] <= in_data_i.sample;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_idx_q];
    end
  end

  // Threshold bound, cut times peak, formed once per vector.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      bound_q <= BoundW'(cut_q) * BoundW'(peak_q);
    end
  end

  // Replay index.
  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.clear) begin
      rd_idx_d = '0;
    end else if (cmd_i.emit_en) begin
      rd_idx_d = rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else begin
      rd_idx_q <= rd_idx_d;
    end
  end

  // Compare the scaled magnitude against the bound.
  assign rd_mag = mag_of(rd_data_q);
  assign lhs    = BoundW'({rd_mag, {FracW{1'b0}}});
  assign below  = (lhs < bound_q);

  // Output register; it frees up when the downstream side takes the request.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      out_data_q.result_sample <= below ? '0 : rd_data_q;
      out_data_q.result_last   <= sts_o.last_idx;
    end
  end

  // Status back to the controller.
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.last_idx = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ rtl/relative_peak_threshold_cut_top.sv @@
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------
// in       | input     | in_valid_i/in_stall_o  | rptc_in_t (sample, is_last)
// out      | output    | out_valid_o/out_stall_i| rptc_out_t (result_sample, result_last)
// cfg      | input     | cfg_valid_i/cfg_ready_o| cut_fraction, 17 bits
//
// While loading, the block takes one sample per cycle; input stalls once the last
// sample of a vector is taken. That sample starts a replay: the bound multiply, then
// for each stored sample a buffer read, then a compare into the output register.
// Reset clears the fill count, peak and cut; the buffer itself needs no clearing.
// A stall on the output holds the replay; input is stalled for the whole replay.
//
// Top level of the relative peak threshold cut block; instantiates rptc_ctrl
// and rptc_dp, uses rptc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "relative_peak_threshold_cut_top_defines.svh"

module relative_peak_threshold_cut_top import rptc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rptc_in_t        in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output rptc_out_t       out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CutW-1:0] cfg_data_i
);

  rptc_cmd_t cmd;
  rptc_sts_t sts;

  // The cut register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Controller.
  rptc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_is_last_i (in_data_i.is_last),
    .sts_i        (sts),
    .in_stall_o   (in_stall_o),
    .cmd_o        (cmd)
  );

  // Datapath.
  rptc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // A result is only loaded into a free output register.
  `RPTC_ASSERT(a_emit_free, !cmd.emit_en || sts.out_free, "emit into an occupied output register")
  // The bound multiply is always followed by the first buffer read.
  `RPTC_ASSERT_IMPLIES(a_mul_then_read, cmd.mul_en, ##1 cmd.rd_en, "replay did not start after multiply")
  // After the final result the block takes input again.
  `RPTC_ASSERT_IMPLIES(a_clear_reopens, cmd.clear, ##1 !in_stall_o, "input not reopened after replay")

endmodule

@@ bench/relative_peak_threshold_cut_checker.sv @@
// Checker for relative_peak_threshold_cut_top: watches the three channels, predicts
// every result request from the accepted input requests, and compares field by field.
// Depends on rptc_pkg for the request types and widths.
`timescale 1ns / 1ps

module relative_peak_threshold_cut_checker import rptc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  rptc_in_t        in_data_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  rptc_out_t       out_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  logic [CutW-1:0] cfg_data_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              stored_o,
  output int              dropped_o,
  output int              vectors_o,
  output int              results_o,
  output int              zeroed_o,
  output int              cut_writes_o
);

  // Predictor state: the vector being collected, its peak and the cut.
  logic signed [SampleW-1:0] held_samples_q[$];
  logic [MagW-1:0]           peak_mag;
  logic [CutW-1:0]           cut_value;
  rptc_out_t                 cut_results_q[$];

  // Unsigned magnitude; the most negative sample maps to 32768.
  function automatic logic [MagW-1:0] abs_sample(input logic signed [SampleW-1:0] s);
    logic [MagW-1:0] raw;
    raw = s;
    if (s < 0) begin
      raw = ~raw + 1'b1;
    end
    return raw;
  endfunction

  // Replay the held vector against the cut and queue the expected results.
  function automatic void predict_cut_vector();
    logic [BoundW-1:0] bound;
    logic [BoundW-1:0] scaled;
    rptc_out_t         res;
    int                n;
    n = held_samples_q.size();
    bound = BoundW'(cut_value) * BoundW'(peak_mag);
    for (int i = 0; i < n; i++) begin
      scaled = BoundW'(abs_sample(held_samples_q[i])) << FracW;
      res.result_last = (i == n - 1);
      if (scaled < bound) begin
        res.result_sample = '0;
        if (held_samples_q[i] != 0) begin
          zeroed_o++;
        end
      end else begin
        res.result_sample = held_samples_q[i];
      end
      cut_results_q.push_back(res);
    end
    held_samples_q.delete();
    peak_mag = '0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rptc_out_t want;
    if (!rst_ni) begin
      held_samples_q.delete();
      cut_results_q.delete();
      peak_mag  = '0;
      cut_value = '0;
      pending_o = 0;
    end else begin
      // A result request is checked against the oldest expectation.
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (cut_results_q.size() == 0) begin
          $error("unexpected result: result_sample %0d result_last %0b",
                 out_data_i.result_sample, out_data_i.result_last);
          fail_count_o++;
        end else begin
          want = cut_results_q.pop_front();
          if (out_data_i.result_sample !== want.result_sample) begin
            $error("result_sample mismatch: expected %0d, actual %0d",
                   want.result_sample, out_data_i.result_sample);
            fail_count_o++;
          end
          if (out_data_i.result_last !== want.result_last) begin
            $error("result_last mismatch: expected %0b, actual %0b",
                   want.result_last, out_data_i.result_last);
            fail_count_o++;
          end
        end
      end

      // Register write.
      if (cfg_valid_i && cfg_ready_i) begin
        cut_value = cfg_data_i;
        cut_writes_o++;
      end

      // Input request: store while there is room, replay on the last mark.
      if (in_valid_i && !in_stall_i) begin
        if (held_samples_q.size() < MaxLength) begin
          held_samples_q.push_back(in_data_i.sample);
          if (abs_sample(in_data_i.sample) > peak_mag) begin
            peak_mag = abs_sample(in_data_i.sample);
          end
          stored_o++;
        end else begin
          dropped_o++;
        end
        if (in_data_i.is_last) begin
          predict_cut_vector();
          vectors_o++;
        end
      end

      pending_o = cut_results_q.size();
    end
  end

endmodule

@@ bench/tb_relative_peak_threshold_cut_top.sv @@
// Testbench top for relative_peak_threshold_cut_top: drives vectors and cut writes,
// stalls the result side at random, and reports the verdict from the checker's count.
// Depends on rptc_pkg, the block itself and relative_peak_threshold_cut_checker.
`timescale 1ns / 1ps

module tb_relative_peak_threshold_cut_top;
  import rptc_pkg::*;

  localparam int HoldCycles   = 300;
  localparam int IdleLimit    = 3000;
  localparam int SettleCycles = 4;
  localparam int TailCycles   = 12;
  localparam int RandomItems  = 112;

  logic            clk          = 1'b0;
  logic            rst_n        = 1'b0;
  logic            in_valid     = 1'b0;
  logic            in_stall;
  rptc_in_t        in_data      = '0;
  logic            out_valid;
  logic            out_stall    = 1'b0;
  rptc_out_t       out_data;
  logic            cfg_valid    = 1'b0;
  logic            cfg_ready;
  logic [CutW-1:0] cfg_data     = '0;

  // Stimulus controls (hold_req is shared with the stall process) and the watchdog counter.
  logic            no_gaps      = 1'b0;
  logic            hold_req     = 1'b0;
  int              idle_cycles  = 0;

  int fail_count, pending, stored, dropped, vectors, results, zeroed, cut_writes;

  relative_peak_threshold_cut_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  relative_peak_threshold_cut_checker checker_inst (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .stored_o     (stored),
    .dropped_o    (dropped),
    .vectors_o    (vectors),
    .results_o    (results),
    .zeroed_o     (zeroed),
    .cut_writes_o (cut_writes)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Result side: random stalls, free-running stretches, and one long hold-off.
  initial begin
    int  pick;
    bit  held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      pick = $urandom_range(0, 99);
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk);
      end else if (pick < 55) begin
        out_stall = 1'b0;
      end else if (pick < 85) begin
        out_stall = 1'b1;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else if (pick < 92) begin
        out_stall = 1'b1;
        repeat ($urandom_range(8, 30)) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no request accepted for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("tb_relative_peak_threshold_cut_top failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Gap before an input request: mostly none, some short, a few long.
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 25);
  endfunction

  // Random sample, often scaled against a per-vector base to land near the cut.
  function automatic logic signed [SampleW-1:0] pick_sample(input int base);
    int pick;
    int val;
    pick = $urandom_range(0, 7);
    case (pick)
      0, 1: begin
        val = $urandom_range(0, 65535) - 32768;
      end
      2: begin
        val = $urandom_range(0, 255);
      end
      3: begin
        case ($urandom_range(0, 4))
          0: val = -32768;
          1: val = 32767;
          2: val = 1;
          3: val = -1;
          default: val = 0;
        endcase
      end
      default: begin
        val = (base * $urandom_range(0, 16)) / 16;
      end
    endcase
    if (pick >= 2 && pick != 3 && $urandom_range(0, 1)) begin
      val = -val;
    end
    return SampleW'(val);
  endfunction

  // Random cut, the extremes among the choices.
  function automatic logic [CutW-1:0] pick_cut();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CutW'(65536);
      2: return CutW'(131071);
      3: return CutW'($urandom_range(0, 131071));
      default: return CutW'($urandom_range(1, 65535));
    endcase
  endfunction

  // Offer one input request; starts and ends at a falling edge.
  task automatic send_sample(input logic signed [SampleW-1:0] value, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.sample  = value;
    in_data.is_last = last;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Let the block drain completely before a register write.
  task automatic settle();
    in_valid = 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_cut(input logic [CutW-1:0] value);
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_vector(input int len);
    int base;
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 32767);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(base), i == len - 1);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int  sent;
    int  len;
    bit  pressure_done;
    sent = 0;
    pressure_done = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Half cut against a full-scale peak: extremes and both sides of the threshold.
    write_cut(CutW'(32768));
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd16384, 1'b0);
    send_sample(-16'sd16383, 1'b0);
    send_sample(16'sd100, 1'b1);

    // Largest cut: an all-zero vector keeps everything, otherwise all nonzero go.
    settle();
    write_cut(CutW'(131071));
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd3, 1'b1);

    // Cut of exactly one: only samples at the peak magnitude survive.
    settle();
    write_cut(CutW'(65536));
    send_sample(-16'sd200, 1'b0);
    send_sample(16'sd200, 1'b0);
    send_sample(16'sd199, 1'b1);

    // Zero cut and a one-sample vector.
    settle();
    write_cut('0);
    send_sample(-16'sd7, 1'b1);

    // Random vectors with occasional cut changes between them.
    while (sent < RandomItems) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        write_cut(pick_cut());
      end
      if (!pressure_done && sent >= 40) begin
        // Long result hold-off over an overflowing vector and the one behind it.
        settle();
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        send_random_vector(MaxLength + 2);
        send_random_vector(4);
        hold_req = 1'b0;
        no_gaps  = 1'b0;
        sent += MaxLength + 4;
        pressure_done = 1'b1;
      end else begin
        len = $urandom_range(1, 10);
        no_gaps = ($urandom_range(0, 3) == 0);
        send_random_vector(len);
        sent += len;
      end
    end

    settle();
    repeat (TailCycles) @(negedge clk);
    $display("Covered %0d vectors: %0d samples stored, %0d dropped at a full buffer, %0d cut writes.",
             vectors, stored, dropped, cut_writes);
    $display("Checked %0d results, %0d nonzero samples zeroed by the cut.", results, zeroed);
    if (fail_count == 0) begin
      $display("tb_relative_peak_threshold_cut_top passed");
    end else begin
      $display("tb_relative_peak_threshold_cut_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rptc_pkg.sv
rtl/rptc_ctrl.sv
rtl/rptc_dp.sv
rtl/relative_peak_threshold_cut_top.sv
bench/relative_peak_threshold_cut_checker.sv
bench/tb_relative_peak_threshold_cut_top.sv
